// ===== rtl/core/bitmap_id_allocator_unit_macros.svh =====
// Assertion macros shared by the id allocator RTL.
// Standalone header; it depends on nothing else.
`ifndef BITMAP_ID_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define BIA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bitmap id allocator: assertion failed");

// Next-cycle implication, checked while reset is released.
`define BIA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bitmap id allocator: assertion failed");

`endif

// ===== rtl/core/bia_pkg.sv =====
// Shared constants, codes and word types of the bitmap id allocator.
// No dependencies; every RTL module imports this package.
package bia_pkg;

	// Pool geometry.
	localparam int NUM_IDS         = 1024;
	localparam int WORD_BITS       = 32;
	localparam int MAX_PER_REQUEST = 16;
	localparam int NUM_WORDS       = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_IDX_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BIT_IDX_W       = $clog2(WORD_BITS);
	localparam int ID_W            = WORD_IDX_W + BIT_IDX_W;
	localparam int CNT_W           = $clog2(MAX_PER_REQUEST + 1);
	localparam int FREE_W          = $clog2(NUM_IDS + 1);
	localparam int LAST_WORD       = NUM_WORDS - 1;
	localparam int TAIL_BITS       = NUM_WORDS * WORD_BITS - NUM_IDS;

	// Bits of the last word that lie past the pool always read as taken.
	localparam logic [WORD_BITS-1:0] WORD_ONES = '1;
	localparam logic [WORD_BITS-1:0] TAIL_MASK = ~(WORD_ONES >> TAIL_BITS);

	// Request kinds.
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_SHORT = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;
	localparam logic [1:0] STAT_FREE  = 2'd3;

	// Command codes from the front end to the back end.
	localparam logic [1:0] OP_REPORT = 2'd0;
	localparam logic [1:0] OP_ALLOC  = 2'd1;
	localparam logic [1:0] OP_FREE   = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [4:0] alloc_count;
		logic [9:0] target_id;
	} bia_req_t;

	typedef struct packed {
		logic [9:0]  granted_id;
		logic [1:0]  status;
		logic        last;
		logic [10:0] free_left;
	} bia_rsp_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [CNT_W-1:0] count;
		logic [ID_W-1:0]  id;
		logic [1:0]       status;
	} bia_cmd_t;

	typedef struct packed {
		logic     valid;
		bia_cmd_t cmd;
	} bia_cmd_chan_t;

endpackage

// ===== rtl/core/bitmap_id_allocator_unit.sv =====
// Bitmap id allocator: a pool of NUM_IDS ids tracked by a bitmap of 32-bit words,
// with first-fit allocation of up to 16 ids per request and single-id release.
// A free request, and any request answered with a single error or empty result,
// is handled at dispatch in the back end. An allocate is dispatched, then the
// scanner reads one bitmap word and claims one id per cycle while the result
// queue has room, passing over fully taken words. Requests queue in a two-word
// command queue while a scan runs, and results leave through a two-word result
// queue; a full result queue stalls both dispatch and the scanner. The bitmap
// is cleared at reset, so every id is free and no warm-up pass is needed.
// Depends on bia_pkg, bia_front and bia_back.
module bitmap_id_allocator_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  bia_pkg::bia_req_t req,
	output logic              empty,
	input  logic              pop,
	output bia_pkg::bia_rsp_t rsp
);
	import bia_pkg::*;

	bia_cmd_chan_t cmd_chan;
	logic          cmd_ready;

	// Front end: classify and queue requests.
	bia_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cmd_chan  (cmd_chan),
		.cmd_ready (cmd_ready)
	);

	// Back end: bitmap updates and result delivery.
	bia_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_chan  (cmd_chan),
		.cmd_ready (cmd_ready),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/core/bia_front.sv =====
// Front end of the id allocator: classifies requests and queues commands.
// Depends on bia_pkg.
module bia_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  bia_pkg::bia_req_t      req,
	output bia_pkg::bia_cmd_chan_t cmd_chan,
	input  logic                   cmd_ready
);
	import bia_pkg::*;

	bia_cmd_t   cmd_new;
	bia_cmd_t   entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push_fire;
	logic       pop_fire;

	// Classify the request; anything decided without the bitmap becomes a report.
	always_comb begin
		cmd_new = '0;
		if (req.kind == KIND_FREE) begin
			if (32'(req.target_id) >= NUM_IDS) begin
				cmd_new.op     = OP_REPORT;
				cmd_new.status = STAT_RANGE;
			end else begin
				cmd_new.op = OP_FREE;
				cmd_new.id = ID_W'(req.target_id);
			end
		end else begin
			if (req.alloc_count == 5'd0) begin
				cmd_new.op     = OP_REPORT;
				cmd_new.status = STAT_OK;
			end else begin
				cmd_new.op = OP_ALLOC;
				if (32'(req.alloc_count) > MAX_PER_REQUEST) begin
					cmd_new.count = CNT_W'(MAX_PER_REQUEST);
				end else begin
					cmd_new.count = CNT_W'(req.alloc_count);
				end
			end
		end
	end

	// Two-word command queue toward the back end.
	assign full      = (cnt_q == 2'd2);
	assign push_fire = push && !full;
	assign cmd_chan  = {(cnt_q != 2'd0), entries_q[rd_ptr_q]};
	assign pop_fire  = cmd_chan.valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_fire) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Queue storage needs no reset.
	always_ff @(posedge clk) begin
		if (push_fire) begin
			entries_q[wr_ptr_q] <= cmd_new;
		end
	end

endmodule

// ===== rtl/core/bia_back.sv =====
// Back end of the id allocator: bitmap, free counter, scan sequencer and
// the result queue. Depends on bia_pkg and the assertion macro header.
`include "bitmap_id_allocator_unit_macros.svh"

module bia_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bia_pkg::bia_cmd_chan_t cmd_chan,
	output logic                   cmd_ready,
	output logic                   empty,
	input  logic                   pop,
	output bia_pkg::bia_rsp_t      rsp
);
	import bia_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                  state_q;
	logic                  state_d;
	logic [WORD_BITS-1:0]  bitmap_q [NUM_WORDS];
	logic [FREE_W-1:0]     free_count_q;
	logic [FREE_W-1:0]     free_count_d;
	logic [WORD_IDX_W-1:0] w_q;
	logic [WORD_IDX_W-1:0] w_d;
	logic [CNT_W-1:0]      want_q;
	logic [CNT_W-1:0]      want_d;
	logic [CNT_W-1:0]      got_q;
	logic [CNT_W-1:0]      got_d;

	logic [WORD_IDX_W-1:0] rd_idx;
	logic [WORD_BITS-1:0]  word;
	logic [WORD_BITS-1:0]  word_eff;
	logic                  zero_found;
	logic [BIT_IDX_W-1:0]  zero_bit;
	logic [BIT_IDX_W-1:0]  free_bit;
	logic [CNT_W-1:0]      got_inc;

	logic                  bm_we;
	logic [WORD_BITS-1:0]  bm_wdata;

	bia_rsp_t              res_data;
	logic                  res_push;
	bia_rsp_t              rq_q [2];
	logic                  rq_wr_q;
	logic                  rq_rd_q;
	logic [1:0]            rq_cnt_q;
	logic                  rq_full;
	logic                  rq_pop;

	assign rq_full   = (rq_cnt_q == 2'd2);
	assign cmd_ready = (state_q == ST_IDLE) && !rq_full;

	// Bitmap word read: the scan word, or the word that holds the id to free.
	assign rd_idx   = (state_q == ST_SCAN) ? w_q : cmd_chan.cmd.id[ID_W-1:BIT_IDX_W];
	assign word     = bitmap_q[rd_idx];
	assign word_eff = (32'(rd_idx) == LAST_WORD) ? (word | TAIL_MASK) : word;
	assign free_bit = cmd_chan.cmd.id[BIT_IDX_W-1:0];
	assign got_inc  = got_q + CNT_W'(1);

	// Lowest clear bit of the scan word.
	always_comb begin
		zero_found = 1'b0;
		zero_bit   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word_eff[i]) begin
				zero_found = 1'b1;
				zero_bit   = BIT_IDX_W'(i);
			end
		end
	end

	// Sequencer: dispatch one command, or claim one id or skip one word.
	always_comb begin
		state_d      = state_q;
		free_count_d = free_count_q;
		w_d          = w_q;
		want_d       = want_q;
		got_d        = got_q;
		bm_we        = 1'b0;
		bm_wdata     = word;
		res_push     = 1'b0;
		res_data     = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_chan.valid && !rq_full) begin
					case (cmd_chan.cmd.op)
						OP_FREE: begin
							res_push      = 1'b1;
							res_data.last = 1'b1;
							if (!word[free_bit]) begin
								res_data.status    = STAT_FREE;
								res_data.free_left = 11'(free_count_q);
							end else begin
								bm_we                = 1'b1;
								bm_wdata[free_bit]   = 1'b0;
								free_count_d         = free_count_q + FREE_W'(1);
								res_data.granted_id  = 10'(cmd_chan.cmd.id);
								res_data.status      = STAT_OK;
								res_data.free_left   = 11'(free_count_d);
							end
						end
						OP_ALLOC: begin
							if (32'(cmd_chan.cmd.count) > 32'(free_count_q)) begin
								res_push           = 1'b1;
								res_data.status    = STAT_SHORT;
								res_data.last      = 1'b1;
								res_data.free_left = 11'(free_count_q);
							end else begin
								state_d = ST_SCAN;
								w_d     = '0;
								want_d  = cmd_chan.cmd.count;
								got_d   = '0;
							end
						end
						default: begin
							res_push           = 1'b1;
							res_data.status    = cmd_chan.cmd.status;
							res_data.last      = 1'b1;
							res_data.free_left = 11'(free_count_q);
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (!zero_found) begin
					w_d = w_q + WORD_IDX_W'(1);
				end else if (!rq_full) begin
					bm_we                = 1'b1;
					bm_wdata[zero_bit]   = 1'b1;
					free_count_d         = free_count_q - FREE_W'(1);
					got_d                = got_inc;
					res_push             = 1'b1;
					res_data.granted_id  = 10'({w_q, zero_bit});
					res_data.status      = STAT_OK;
					res_data.last        = (got_inc == want_q);
					res_data.free_left   = 11'(free_count_d);
					if (got_inc == want_q) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer registers, bitmap and free counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			free_count_q <= FREE_W'(NUM_IDS);
			w_q          <= '0;
			want_q       <= '0;
			got_q        <= '0;
			for (int i = 0; i < NUM_WORDS; i++) begin
				bitmap_q[i] <= '0;
			end
		end else begin
			state_q      <= state_d;
			free_count_q <= free_count_d;
			w_q          <= w_d;
			want_q       <= want_d;
			got_q        <= got_d;
			if (bm_we) begin
				bitmap_q[rd_idx] <= bm_wdata;
			end
		end
	end

	// Two-word result queue toward the output port.
	assign empty  = (rq_cnt_q == 2'd0);
	assign rsp    = rq_q[rq_rd_q];
	assign rq_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= 1'b0;
			rq_rd_q  <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				rq_wr_q <= ~rq_wr_q;
			end
			if (rq_pop) begin
				rq_rd_q <= ~rq_rd_q;
			end
			if (res_push && !rq_pop) begin
				rq_cnt_q <= rq_cnt_q + 2'd1;
			end else if (rq_pop && !res_push) begin
				rq_cnt_q <= rq_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_q[rq_wr_q] <= res_data;
		end
	end

	// The counter never claims more free ids than the pool holds.
	`BIA_ASSERT_IMP(a_free_bound, clk, arst_n, 1'b1, 32'(free_count_q) <= NUM_IDS)
	// A running scan always has enough free ids left to finish.
	`BIA_ASSERT_IMP(a_scan_enough, clk, arst_n, state_q == ST_SCAN,
		(got_q < want_q) && (32'(want_q - got_q) <= 32'(free_count_q)))
	// The final id of a run returns the sequencer to idle.
	`BIA_ASSERT_NXT(a_scan_done, clk, arst_n,
		(state_q == ST_SCAN) && res_push && res_data.last, state_q == ST_IDLE)
	// The result queue is written only when it has room.
	`BIA_ASSERT_IMP(a_rq_room, clk, arst_n, res_push, !rq_full || rq_pop == 1'b0 && !rq_full)

endmodule
